/* rtl/nearest_centroid_classifier_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-centroid classifier checks
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_CLASSIFIER_ASSERT_SVH
`define NEAREST_CENTROID_CLASSIFIER_ASSERT_SVH

// Property checked outside reset.
`define NCC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Property checked at every edge, reset included.
`define NCC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

/* rtl/ncc_pkg.sv */
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared widths, codes and types of the nearest-centroid classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncc_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 256;

  localparam int CLUSTER_W = 4;
  localparam int ELEM_W    = 8;
  localparam int VALUE_W   = 16;
  localparam int LABEL_W   = 4;
  localparam int NUMCL_W   = 5;
  localparam int DIMS_W    = 9;
  localparam int SQ_W      = 2 * VALUE_W;
  localparam int SUM_W     = 48;

  localparam int CENT_DEPTH = MAX_CLUSTERS * MAX_DIMS;
  localparam int CENT_AW    = $clog2(CENT_DEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS         = 1'd1;

  localparam logic KIND_CENTROID = 1'b0;
  localparam logic KIND_POINT    = 1'b1;

  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [CLUSTER_W-1:0] cluster_t;

endpackage

/* rtl/nearest_centroid_classifier.sv */
// ----------------------------------------------------------------------------
// nearest_centroid_classifier
// k-means nearest-centroid labelling with squared L2 distance, Q8.8 data.
// ----------------------------------------------------------------------------
// channel | dir | signals                          | contents
// s_      | in  | s_tvalid s_tready s_tdata s_tuser| centroid or point element
// m_      | out | m_tvalid m_tready m_tdata        | label of nearest centroid
// cfg_    | in  | cfg_valid cfg_ready cfg_index    | num_clusters, dims
//         |     | cfg_data                         |
//
// A centroid word is one write to the centroid RAM.
// A point word does one accumulator RAM read-modify-write per active cluster
// through a 3-stage read/square/add pipeline.
// The last element of a point also loads the output register.
// Reset clears control only; accumulator valid bits make sums read as zero.
// A held label stalls the input only once the next point has ended.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_centroid_classifier
  import ncc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // cluster_index[3:0], element_index[11:4],
                                           // value[27:12], zero[31:28]
  input  logic [0:0]            s_tuser,   // kind[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // label[3:0], zero[7:4]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ELEM_AW = $clog2(MAX_DIMS);

  // input word fields
  logic                      in_kind;
  cluster_t                  in_cluster;
  logic [ELEM_W-1:0]         in_elem;
  logic [VALUE_W-1:0]        in_value;
  logic                      in_accept;

  assign in_kind    = s_tuser[0];
  assign in_cluster = s_tdata[3:0];
  assign in_elem    = s_tdata[11:4];
  assign in_value   = s_tdata[27:12];
  assign in_accept  = s_tvalid && s_tready;

  // configuration
  logic [NUMCL_W-1:0] num_clusters;
  logic [DIMS_W-1:0]  dims;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= NUMCL_W'(1);
      dims         <= DIMS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_CLUSTERS: num_clusters <= cfg_data[NUMCL_W-1:0];
        CFG_DIMS:         dims         <= cfg_data[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // active cluster count minus one, active dims
  cluster_t          kmax_in;
  logic [DIMS_W-1:0] dims_act;
  logic              in_range;
  logic              in_final;

  always_comb begin
    if (num_clusters == '0) begin
      kmax_in = '0;
    end else if (num_clusters > NUMCL_W'(MAX_CLUSTERS)) begin
      kmax_in = CLUSTER_W'(MAX_CLUSTERS - 1);
    end else begin
      kmax_in = CLUSTER_W'(num_clusters - NUMCL_W'(1));
    end
    dims_act = (dims > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims;
    in_range = {1'b0, in_elem} < dims_act;
    in_final = {1'b0, in_elem} == (dims_act - DIMS_W'(1));
  end

  // point control and pipeline
  logic               busy;
  cluster_t           issue_idx;
  cluster_t           kmax;
  logic [ELEM_W-1:0]  pt_elem;
  logic [VALUE_W-1:0] pt_value;
  logic               pt_first;
  logic               pt_final;

  logic               s1_valid;
  cluster_t           s1_idx;
  logic               s1_last;
  logic               s1_sum_vld;

  logic               s2_valid;
  cluster_t           s2_idx;
  logic               s2_last;
  logic [SQ_W-1:0]    s2_sq;
  sum_t               s2_base;

  sum_t               best_sum;
  cluster_t           best_idx;
  logic               pend;
  logic [LABEL_W-1:0] label;

  logic [MAX_CLUSTERS-1:0] sum_valid;

  logic [VALUE_W-1:0] cent_rdata;
  sum_t               sum_rdata;
  sum_t               new_sum;

  logic signed [VALUE_W:0] diff;
  logic [VALUE_W-1:0]      mag;

  // one item in flight; held result blocks only until it moves out
  assign s_tready = !busy && !s1_valid && !s2_valid && !pend;

  always_comb begin
    diff    = $signed({pt_value[VALUE_W-1], pt_value})
            - $signed({cent_rdata[VALUE_W-1], cent_rdata});
    mag     = diff[VALUE_W] ? VALUE_W'(-diff) : VALUE_W'(diff);
    new_sum = s2_base + SUM_W'(s2_sq);
  end

  ncc_ram #(
    .DEPTH (CENT_DEPTH),
    .WIDTH (VALUE_W)
  ) u_cent_ram (
    .clk   (clk),
    .we    (in_accept && (in_kind == KIND_CENTROID)),
    .waddr ({in_cluster, in_elem[ELEM_AW-1:0]}),
    .wdata (in_value),
    .raddr ({issue_idx, pt_elem[ELEM_AW-1:0]}),
    .rdata (cent_rdata)
  );

  ncc_ram #(
    .DEPTH (MAX_CLUSTERS),
    .WIDTH (SUM_W)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s2_valid),
    .waddr (s2_idx),
    .wdata (new_sum),
    .raddr (issue_idx),
    .rdata (sum_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issue_idx <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      pend      <= 1'b0;
      m_tvalid  <= 1'b0;
      sum_valid <= '0;
    end else begin
      if (in_accept && (in_kind == KIND_POINT) && in_range) begin
        busy      <= 1'b1;
        issue_idx <= '0;
      end else if (busy) begin
        if (issue_idx == kmax) begin
          busy <= 1'b0;
        end else begin
          issue_idx <= issue_idx + CLUSTER_W'(1);
        end
      end

      s1_valid <= busy;
      s2_valid <= s1_valid;

      if (s2_valid) begin
        sum_valid[s2_idx] <= 1'b1;
      end

      if (s2_valid && s2_last && pt_final) begin
        pend <= 1'b1;
      end else if (pend && (!m_tvalid || m_tready)) begin
        pend <= 1'b0;
      end

      if (pend && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept && (in_kind == KIND_POINT) && in_range) begin
      kmax     <= kmax_in;
      pt_elem  <= in_elem;
      pt_value <= in_value;
      pt_first <= (in_elem == '0);
      pt_final <= in_final;
    end

    s1_idx     <= issue_idx;
    s1_last    <= (issue_idx == kmax);
    s1_sum_vld <= sum_valid[issue_idx];

    // element zero restarts the sum; never-written sums read as zero
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s2_sq   <= SQ_W'(mag) * SQ_W'(mag);
    s2_base <= (pt_first || !s1_sum_vld) ? '0 : sum_rdata;

    // running minimum, strict compare keeps the lowest index on ties
    if (s2_valid && ((s2_idx == '0) || (new_sum < best_sum))) begin
      best_sum <= new_sum;
      best_idx <= s2_idx;
    end

    if (pend && (!m_tvalid || m_tready)) begin
      label <= best_idx;
    end
  end

  assign m_tdata = {4'b0, label};

endmodule

/* rtl/ncc_ram.sv */
// ----------------------------------------------------------------------------
// ncc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ncc_checker.sv */
// ----------------------------------------------------------------------------
// ncc_checker
// Port-level checks of the nearest-centroid classifier, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nearest_centroid_classifier_assert.svh"

module ncc_checker
  import ncc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [31:0]           s_tdata,
  input logic [0:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [7:0]            m_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic point_word;
  assign point_word = s_tvalid && s_tready && (s_tuser[0] == KIND_POINT);

  // a stalled label holds
  `NCC_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // no label straight out of reset
  `NCC_ASSERT_ALWAYS(a_out_reset, clk, rst |=> !m_tvalid)

  // pad bits above the label stay clear
  `NCC_ASSERT(a_out_pad, clk, rst, m_tvalid |-> m_tdata[7:4] == 4'b0)

  // the input stalls only once a point word has entered the pipeline
  `NCC_ASSERT(a_point_busy, clk, rst, $fell(s_tready) |-> $past(point_word))

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-centroid classifier: centroid and point
// words go in over the stream port, labels are predicted per point and matched
// against the master stream in order, under random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ncc_pkg::*;

  localparam int SETTLE     = 40;    // cycles for a point word to drain
  localparam int IDLE_LIMIT = 5000;  // watchdog, cycles without any handshake
  localparam int SQUEEZE    = 400;   // long receiver hold-off

  // Predicts labels and keeps the ones still owed by the block.
  class label_scoreboard;
    logic [VALUE_W-1:0] cstore [CENT_DEPTH];
    logic [SUM_W-1:0]   sums [MAX_CLUSTERS];
    logic [4:0]         ncl;
    logic [8:0]         ndims;
    logic [3:0]         pending_labels [$];
    int                 mismatches;
    int                 labels_made;

    function new();
      foreach (cstore[i]) cstore[i] = '0;
      foreach (sums[i]) sums[i] = '0;
      ncl = 5'd1;
      ndims = 9'd1;
      mismatches = 0;
      labels_made = 0;
    endfunction

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_NUM_CLUSTERS) ncl = data[4:0];
      else ndims = data;
    endfunction

    function int active_k();
      if (ncl == 0) return 1;
      if (ncl > MAX_CLUSTERS) return MAX_CLUSTERS;
      return int'(ncl);
    endfunction

    function int active_d();
      return (ndims > MAX_DIMS) ? MAX_DIMS : int'(ndims);
    endfunction

    function void note_word(logic kind, logic [3:0] ci, logic [7:0] ei,
                            logic [VALUE_W-1:0] v);
      int d;
      int k;
      int best;
      int diff;
      longint sq;
      logic [SUM_W-1:0] base;
      logic [SUM_W-1:0] best_sum;
      if (kind == KIND_CENTROID) begin
        cstore[int'({ci, ei})] = v;
        return;
      end
      d = active_d();
      if (int'(ei) >= d) return;
      k = active_k();
      for (int c = 0; c < k; c++) begin
        diff = int'($signed(v)) - int'($signed(cstore[c * MAX_DIMS + int'(ei)]));
        sq = longint'(diff) * longint'(diff);
        base = (ei == 0) ? '0 : sums[c];
        sums[c] = base + SUM_W'(sq);
      end
      if (int'(ei) != d - 1) return;
      best = 0;
      best_sum = sums[0];
      for (int c = 1; c < k; c++) begin
        if (sums[c] < best_sum) begin
          best_sum = sums[c];
          best = c;
        end
      end
      pending_labels.push_back(4'(best));
      labels_made++;
    endfunction

    function void check_label(logic [3:0] got);
      logic [3:0] want;
      if (pending_labels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("label %0d arrived with none outstanding", got);
        return;
      end
      want = pending_labels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("label mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;   // cluster_index[3:0], element_index[11:4],
                                         // value[27:12], zero[31:28]
  logic [0:0]            s_tuser = '0;   // kind[0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;        // label[3:0], zero[7:4]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  label_scoreboard board = new();
  bit loaded [CENT_DEPTH];
  bit calm = 1'b0;
  bit squeeze_pending = 1'b0;
  bit squeeze_done = 1'b0;
  int words_sent = 0;
  int idle_cycles = 0;

  nearest_centroid_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_label(m_tdata[3:0]);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: ready bursts, stall bursts, one long hold-off.
  initial begin
    @(negedge rst);
    forever begin
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (SQUEEZE) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return 16'($urandom_range(0, 4)) - 16'd2;  // small values, ties likely
      default: return 16'($urandom);
    endcase
  endfunction

  // Called and returns at a falling edge.
  task automatic send_word(input logic kind, input logic [3:0] ci, input logic [7:0] ei,
                           input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'd0, v, ei, ci};
    if (kind == KIND_CENTROID) loaded[int'({ci, ei})] = 1'b1;
    if (kind == KIND_CENTROID || int'(ei) < board.active_d()) words_sent++;
    // hold off while short points stream, so labels pile up
    if (words_sent >= 100 && !squeeze_done && kind == KIND_POINT &&
        board.active_d() > 0 && board.active_d() <= 8) begin
      squeeze_done = 1'b1;
      squeeze_pending = 1'b1;
    end
    do @(posedge clk); while (!s_tready);
    board.note_word(kind, ci, ei, v);
    @(negedge clk);
  endtask

  task automatic send_centroid(input int c, input int e, input logic [VALUE_W-1:0] v);
    send_word(KIND_CENTROID, 4'(c), 8'(e), v);
  endtask

  task automatic send_point(input int e, input logic [VALUE_W-1:0] v);
    send_word(KIND_POINT, 4'($urandom), 8'(e), v);
  endtask

  // Registers change only once the block has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    s_tvalid <= 1'b0;
    while (board.pending_labels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.note_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] ncl_data, input logic [8:0] dims_data,
                           input int npoints);
    int k;
    int d;
    int n;
    int shape;
    write_reg(CFG_NUM_CLUSTERS, ncl_data);
    write_reg(CFG_DIMS, dims_data);
    k = board.active_k();
    d = board.active_d();
    // load every entry a point can read, refresh some at random
    for (int c = 0; c < k; c++)
      for (int e = 0; e < d; e++)
        if (!loaded[c * MAX_DIMS + e] || $urandom_range(0, 3) == 0)
          send_centroid(c, e, pick_value());
    for (int p = 0; p < npoints; p++) begin
      shape = $urandom_range(0, 9);
      if (d == 0 || (shape == 9 && d < MAX_DIMS)) begin
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++) send_point($urandom_range(d, 255), pick_value());
      end else if (shape == 8 && d > 1) begin
        n = $urandom_range(1, d - 1);  // abandoned point
        for (int e = 0; e < n; e++) send_point(e, pick_value());
      end else if (shape == 7) begin
        n = $urandom_range(1, d + 2);  // elements out of order
        for (int j = 0; j < n; j++) send_point($urandom_range(0, d - 1), pick_value());
      end else begin
        for (int e = 0; e < d; e++) begin
          send_point(e, pick_value());
          if ($urandom_range(0, 15) == 0) begin
            if (d < MAX_DIMS && $urandom_range(0, 1) == 1)
              send_point($urandom_range(d, 255), pick_value());
            else
              send_centroid($urandom_range(0, 15), $urandom_range(0, 255), pick_value());
          end
        end
      end
    end
  endtask

  initial begin
    int sel;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: one cluster, one element
    send_centroid(0, 0, 16'h8000);
    send_point(0, 16'h7FFF);             // widest possible difference
    send_centroid(15, 255, 16'h7FFF);    // top corner, stored beyond dims
    send_point(200, 16'h1234);           // beyond dims, ignored

    write_reg(CFG_NUM_CLUSTERS, 9'h1E3); // upper bits dropped, three clusters
    write_reg(CFG_DIMS, 9'd2);
    send_centroid(0, 0, 16'h0400);
    send_centroid(0, 1, 16'h0400);
    send_centroid(1, 0, 16'h0010);
    send_centroid(1, 1, 16'h0000);
    send_centroid(2, 0, 16'h0000);
    send_centroid(2, 1, 16'h0010);
    send_point(0, 16'h0000);
    send_point(1, 16'h0000);             // clusters 1 and 2 tie
    send_point(1, 16'h0010);             // last element with no element zero first
    send_point(0, 16'h0000);
    send_point(1, 16'h0000);

    write_reg(CFG_NUM_CLUSTERS, 9'h020); // low bits zero, acts as one cluster
    send_point(0, 16'hFFFF);
    send_point(1, 16'h8000);

    write_reg(CFG_DIMS, 9'd0);           // nothing ever completes
    send_point(0, 16'h0001);
    send_point(255, 16'h7FFF);

    run_phase({4'hA, 5'd31}, 9'd3, 4);   // cluster count saturates

    // dims saturates to 256: element 255 ends the point
    write_reg(CFG_NUM_CLUSTERS, 9'h1E2);
    write_reg(CFG_DIMS, 9'h1FF);
    send_centroid(0, 255, pick_value());
    send_centroid(1, 255, pick_value());
    send_point(0, pick_value());
    send_point(1, pick_value());
    send_point(255, pick_value());

    while (words_sent < 500 || board.labels_made < 40) begin
      sel = $urandom_range(0, 19);
      if (sel == 0)
        run_phase({4'($urandom), 5'd0}, 9'($urandom_range(1, 6)), 4);
      else if (sel == 1)
        run_phase({4'($urandom), 5'($urandom_range(17, 31))}, 9'($urandom_range(1, 4)), 4);
      else if (sel == 2)
        run_phase({4'($urandom), 5'($urandom_range(1, 16))}, 9'd0, 3);
      else
        run_phase({4'($urandom), 5'($urandom_range(1, 16))}, 9'($urandom_range(1, 8)),
                  $urandom_range(2, 6));
      calm = (words_sent >= 430);
    end

    s_tvalid <= 1'b0;
    while (board.pending_labels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0 && board.pending_labels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* nearest_centroid_classifier.f */
+incdir+rtl
rtl/ncc_pkg.sv
rtl/ncc_ram.sv
rtl/nearest_centroid_classifier.sv
rtl/ncc_checker.sv
tb/tb.sv
